// ===== hdl/hrt_pkg.sv =====
// ----------------------------------------------------------------------------
// hrt_pkg: shared types and constants for the HTTP request head tokenizer
// Byte codes, parse phases, result kinds and the result record layout.
// ----------------------------------------------------------------------------
package hrt_pkg;

    localparam int BUFFER_BYTES = 4096;
    localparam int MAX_HEADERS  = 32;

    // offset counter holds 0..BUFFER_BYTES
    localparam int OFF_W   = $clog2(BUFFER_BYTES) + 1;
    // header counter holds 0..MAX_HEADERS
    localparam int HC_W    = $clog2(MAX_HEADERS + 1);

    // result field widths on the port
    localparam int FIELD_W = 13;
    localparam int HDR_W   = 5;

    // result queue between front and back
    localparam int QDEPTH  = 4;
    localparam int QPTR_W  = $clog2(QDEPTH);

    localparam logic [7:0] CH_SP    = 8'h20;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_COLON = 8'h3A;
    localparam logic [7:0] CH_TAB   = 8'h09;

    typedef enum logic [3:0] {
        PH_METHOD    = 4'd0,
        PH_URI       = 4'd1,
        PH_VERSION   = 4'd2,
        PH_SKIP      = 4'd3,
        PH_LINESTART = 4'd4,
        PH_NAME      = 4'd5,
        PH_VSPACE    = 4'd6,
        PH_VALUE     = 4'd7,
        PH_DRAIN     = 4'd8
    } phase_t;

    typedef enum logic [2:0] {
        EV_METHOD  = 3'd0,
        EV_URI     = 3'd1,
        EV_VERSION = 3'd2,
        EV_NAME    = 3'd3,
        EV_VALUE   = 3'd4,
        EV_DONE    = 3'd5,
        EV_ERROR   = 3'd6
    } ev_kind_t;

    typedef enum logic [1:0] {
        CAUSE_TRUNC = 2'd0,
        CAUSE_FOLD  = 2'd1,
        CAUSE_MANY  = 2'd2
    } cause_t;

    typedef struct packed {
        ev_kind_t             kind;
        logic [FIELD_W-1:0]   start;
        logic [FIELD_W-1:0]   len;
        logic [HDR_W-1:0]     hdr;
        logic [FIELD_W-1:0]   endp;
        cause_t               cause;
    } res_t;

    // all results caused by one input item
    typedef struct packed {
        res_t r0;
        res_t r1;
        logic two;
    } entry_t;

    function automatic res_t mk_res(ev_kind_t k, logic [OFF_W-1:0] s,
                                    logic [OFF_W-1:0] l, logic [HC_W-1:0] h,
                                    logic [OFF_W-1:0] ep, cause_t c);
        res_t r;
        r.kind  = k;
        r.start = FIELD_W'(s);
        r.len   = FIELD_W'(l);
        r.hdr   = HDR_W'(h);
        r.endp  = FIELD_W'(ep);
        r.cause = c;
        return r;
    endfunction

endpackage

// ===== hdl/http_request_head_tokenizer.sv =====
// ----------------------------------------------------------------------------
// http_request_head_tokenizer: HTTP request head tokenizer
// Reports method, URI, version, header names and values, then done or error.
//
//   Channel   Dir  Payload                                      Marker
//   s_axis    in   tdata: data_byte[7:0]                        tlast: end_of_buffer
//   m_axis    out  tdata: start/len/hdr/end/cause, tuser: kind  tlast: last_in_run
//
// One byte is accepted per cycle while the result queue is not full; the front
// parse state updates in that cycle. A byte with two results is sent as two
// output transfers; a four-entry result queue absorbs such bursts and output stalls.
// Reset clears the parse state and output select and empties the queue; queue storage is not swept.
// s_axis_tready drops only while the result queue is full.
// ----------------------------------------------------------------------------
module http_request_head_tokenizer
    import hrt_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] data_byte
    input  logic        s_axis_tlast,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // [12:0] start_offset, [25:13] token_length, [30:26] header_number,
    // [43:31] end_position, [45:44] error_cause, [47:46] zero
    output logic [47:0] m_axis_tdata,
    output logic [2:0]  m_axis_tuser,   // [2:0] event_kind
    output logic        m_axis_tlast
);

    logic   q_push, q_pop, q_empty, q_full;
    entry_t q_in, q_head;
    res_t   res;

    hrt_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_axis_tvalid),
        .in_ready (s_axis_tready),
        .in_byte  (s_axis_tdata),
        .in_eob   (s_axis_tlast),
        .q_full   (q_full),
        .q_push   (q_push),
        .q_entry  (q_in)
    );

    hrt_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (q_push),
        .push_entry (q_in),
        .pop        (q_pop),
        .head       (q_head),
        .empty      (q_empty),
        .full       (q_full)
    );

    hrt_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .head      (q_head),
        .empty     (q_empty),
        .pop       (q_pop),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_res   (res),
        .out_last  (m_axis_tlast)
    );

    assign m_axis_tuser = res.kind;
    assign m_axis_tdata = {2'b00, res.cause, res.endp, res.hdr, res.len, res.start};

endmodule

// ===== hdl/hrt_front.sv =====
// ----------------------------------------------------------------------------
// hrt_front: byte classifier and parse state
// Accepts one byte per cycle unless q_full; advances the parse and forms result records.
// ----------------------------------------------------------------------------
module hrt_front
    import hrt_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [7:0] in_byte,
    input  logic       in_eob,
    input  logic       q_full,
    output logic       q_push,
    output entry_t     q_entry
);

    phase_t            phase_reg, phase_next;
    logic [OFF_W-1:0]  off_reg, off_next;
    logic [OFF_W-1:0]  tstart_reg, tstart_next;
    logic [HC_W-1:0]   hcnt_reg, hcnt_next;

    logic              fire;
    res_t              p_res, e_res;
    logic              p_v, e_v;
    logic              done, failed, abort;
    logic [OFF_W-1:0]  pos, reach, vstart;
    logic [HC_W:0]     hcnt_inc;

    assign in_ready = !q_full;
    assign fire     = in_valid && in_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= PH_METHOD;
            off_reg    <= '0;
            tstart_reg <= '0;
            hcnt_reg   <= '0;
        end
        else if (fire)
        begin
            phase_reg  <= phase_next;
            off_reg    <= off_next;
            tstart_reg <= tstart_next;
            hcnt_reg   <= hcnt_next;
        end
    end

    always_comb
    begin
        phase_next  = phase_reg;
        off_next    = off_reg;
        tstart_next = tstart_reg;
        hcnt_next   = hcnt_reg;
        p_res       = '0;
        e_res       = '0;
        p_v         = 1'b0;
        e_v         = 1'b0;
        done        = 1'b0;
        failed      = 1'b0;
        abort       = 1'b0;
        pos         = off_reg;
        reach       = off_reg + OFF_W'(1);
        vstart      = (phase_reg == PH_VSPACE) ? off_reg : tstart_reg;
        hcnt_inc    = {1'b0, hcnt_reg} + (HC_W+1)'(1);

        if (phase_reg == PH_DRAIN)
        begin
            abort = 1'b1;
            if (in_eob)
            begin
                phase_next  = PH_METHOD;
                off_next    = '0;
                tstart_next = '0;
                hcnt_next   = '0;
            end
        end
        else if (pos >= OFF_W'(BUFFER_BYTES))
        begin
            p_res  = mk_res(EV_ERROR, '0, '0, '0, OFF_W'(BUFFER_BYTES), CAUSE_TRUNC);
            p_v    = 1'b1;
            failed = 1'b1;
        end
        else
        begin
            case (phase_reg)
                PH_METHOD, PH_URI:
                begin
                    if (in_byte == CH_SP)
                    begin
                        p_res = mk_res((phase_reg == PH_METHOD) ? EV_METHOD : EV_URI,
                                       tstart_reg, pos - tstart_reg, '0, '0, CAUSE_TRUNC);
                        p_v         = 1'b1;
                        phase_next  = (phase_reg == PH_METHOD) ? PH_URI : PH_VERSION;
                        tstart_next = pos + OFF_W'(1);
                    end
                end
                PH_VERSION:
                begin
                    if (in_byte == CH_CR)
                    begin
                        p_res = mk_res(EV_VERSION, tstart_reg, pos - tstart_reg,
                                       '0, '0, CAUSE_TRUNC);
                        p_v        = 1'b1;
                        phase_next = PH_SKIP;
                        reach      = pos + OFF_W'(2);
                    end
                end
                PH_SKIP:
                begin
                    phase_next = PH_LINESTART;
                end
                PH_LINESTART:
                begin
                    if (in_byte == CH_CR)
                    begin
                        p_res = mk_res(EV_DONE, '0, '0, '0, pos + OFF_W'(2), CAUSE_TRUNC);
                        p_v   = 1'b1;
                        done  = 1'b1;
                    end
                    else if (in_byte == CH_SP || in_byte == CH_TAB)
                    begin
                        p_res  = mk_res(EV_ERROR, '0, '0, '0, pos, CAUSE_FOLD);
                        p_v    = 1'b1;
                        failed = 1'b1;
                    end
                    else
                    begin
                        tstart_next = pos;
                        if (in_byte == CH_COLON)
                        begin
                            p_res = mk_res(EV_NAME, pos, '0, hcnt_reg, '0, CAUSE_TRUNC);
                            p_v        = 1'b1;
                            phase_next = PH_VSPACE;
                        end
                        else
                        begin
                            phase_next = PH_NAME;
                        end
                    end
                end
                PH_NAME:
                begin
                    if (in_byte == CH_COLON)
                    begin
                        p_res = mk_res(EV_NAME, tstart_reg, pos - tstart_reg,
                                       hcnt_reg, '0, CAUSE_TRUNC);
                        p_v        = 1'b1;
                        phase_next = PH_VSPACE;
                    end
                end
                PH_VSPACE, PH_VALUE:
                begin
                    // skip spaces ahead of the value
                    if (!(phase_reg == PH_VSPACE && in_byte == CH_SP))
                    begin
                        tstart_next = vstart;
                        phase_next  = PH_VALUE;
                        if (in_byte == CH_CR)
                        begin
                            p_res = mk_res(EV_VALUE, vstart, pos - vstart,
                                           hcnt_reg, '0, CAUSE_TRUNC);
                            p_v        = 1'b1;
                            hcnt_next  = hcnt_inc[HC_W-1:0];
                            phase_next = PH_SKIP;
                            reach      = pos + OFF_W'(2);
                            if (hcnt_inc >= (HC_W+1)'(MAX_HEADERS))
                            begin
                                e_res  = mk_res(EV_ERROR, '0, '0, '0, pos + OFF_W'(2),
                                                CAUSE_MANY);
                                e_v    = 1'b1;
                                failed = 1'b1;
                            end
                        end
                    end
                end
                default:
                begin
                    abort       = 1'b1;
                    phase_next  = PH_METHOD;
                    off_next    = '0;
                    tstart_next = '0;
                    hcnt_next   = '0;
                end
            endcase

            if (!abort && !done && !failed && in_eob)
            begin
                e_res  = mk_res(EV_ERROR, '0, '0, '0, reach, CAUSE_TRUNC);
                e_v    = 1'b1;
                failed = 1'b1;
            end
        end

        if (!abort)
        begin
            if (done || failed)
            begin
                if (in_eob)
                begin
                    phase_next  = PH_METHOD;
                    off_next    = '0;
                    tstart_next = '0;
                    hcnt_next   = '0;
                end
                else
                begin
                    phase_next = PH_DRAIN;
                end
            end
            else
            begin
                off_next = pos + OFF_W'(1);
            end
        end
    end

    // pack results in order: token or first error, then trailing error
    assign q_entry.r0  = p_v ? p_res : e_res;
    assign q_entry.r1  = e_res;
    assign q_entry.two = p_v && e_v;
    assign q_push      = fire && (p_v || e_v);

endmodule

// ===== hdl/hrt_queue.sv =====
// ----------------------------------------------------------------------------
// hrt_queue: result queue
// Small register FIFO of per-item result entries between front and back.
// ----------------------------------------------------------------------------
module hrt_queue
    import hrt_pkg::*;
(
    input  logic   clk,
    input  logic   rst_n,
    input  logic   push,
    input  entry_t push_entry,
    input  logic   pop,
    output entry_t head,
    output logic   empty,
    output logic   full
);

    entry_t              mem_reg [QDEPTH];
    logic [QPTR_W-1:0]   wr_ptr_reg, rd_ptr_reg;
    logic [QPTR_W:0]     cnt_reg;

    assign empty = (cnt_reg == '0);
    assign full  = (cnt_reg == (QPTR_W+1)'(QDEPTH));
    assign head  = mem_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_entry;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + QPTR_W'(1);
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + QPTR_W'(1);
            end
            if (push && !pop)
            begin
                cnt_reg <= cnt_reg + (QPTR_W+1)'(1);
            end
            else if (pop && !push)
            begin
                cnt_reg <= cnt_reg - (QPTR_W+1)'(1);
            end
        end
    end

endmodule

// ===== hdl/hrt_back.sv =====
// ----------------------------------------------------------------------------
// hrt_back: result emitter
// Sends the one or two results of each queued entry, marking the last one.
// ----------------------------------------------------------------------------
module hrt_back
    import hrt_pkg::*;
(
    input  logic   clk,
    input  logic   rst_n,
    input  entry_t head,
    input  logic   empty,
    output logic   pop,
    output logic   out_valid,
    input  logic   out_ready,
    output res_t   out_res,
    output logic   out_last
);

    logic sel_reg, sel_next;
    logic fire;

    assign out_valid = !empty;
    assign out_res   = sel_reg ? head.r1 : head.r0;
    assign out_last  = !head.two || sel_reg;
    assign fire      = out_valid && out_ready;
    assign pop       = fire && out_last;

    always_comb
    begin
        sel_next = sel_reg;
        if (fire)
        begin
            // advance to the second result or release the entry
            sel_next = !out_last;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sel_reg <= 1'b0;
        end
        else
        begin
            sel_reg <= sel_next;
        end
    end

endmodule
